>>> hdl/sorted_list_insert_remove_unit_defines.svh
// Assertion macros shared by the sorted list checker.
// Depends on nothing; expects clk_i and rst_ni in the scope of each use.
`ifndef SORTED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define SLRIU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SLRIU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/slriu_pkg.sv
// Package for the sorted list insert/remove unit: codes, widths, cell control.
// No dependencies.
package slriu_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                      wr_en;   // request accepted and it changes the table
    logic                      insert;  // 1 insert, 0 remove
    logic signed [VALUE_W-1:0] value;
  } cell_bcast_t;

endpackage

>>> hdl/slriu_cell.sv
// One slot of the sorted chain: holds a value, compares it to the broadcast
// value and shifts toward a neighbor. Depends on slriu_pkg.
module slriu_cell (
  input  logic                                   clk_i,
  input  slriu_pkg::cell_bcast_t                 bcast_i,
  input  logic                                   occupied_i,
  input  logic                                   left_lt_i,
  input  logic signed [slriu_pkg::VALUE_W-1:0]   left_value_i,
  input  logic signed [slriu_pkg::VALUE_W-1:0]   right_value_i,
  output logic                                   lt_o,
  output logic                                   eq_o,
  output logic signed [slriu_pkg::VALUE_W-1:0]   value_o
);

  logic signed [slriu_pkg::VALUE_W-1:0] value_q;
  logic signed [slriu_pkg::VALUE_W-1:0] value_d;

  assign lt_o    = occupied_i && (value_q < bcast_i.value);
  assign eq_o    = occupied_i && (value_q == bcast_i.value);
  assign value_o = value_q;

  // Cells below the split point keep their value; from it on, an insert
  // shifts right (new value lands at the split), a remove shifts left.
  always_comb begin
    value_d = value_q;
    if (bcast_i.wr_en && !lt_o) begin
      if (bcast_i.insert) begin
        value_d = left_lt_i ? bcast_i.value : left_value_i;
      end else begin
        value_d = right_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> hdl/sorted_list_insert_remove_unit.sv
// Sorted list insert/remove unit: top level with request handling, count
// register and a chain of slriu_cell slots. Depends on slriu_pkg, slriu_cell.
//
// Usage:
//   Requests enter on the s_axis channel: tuser selects insert (0) or
//   remove (1), tdata carries the signed 32-bit value. Each request yields
//   exactly one response on m_axis: status and the count after the request.
//   The table holds up to CAPACITY values in ascending order; an insert goes
//   before existing equal values, a remove deletes the first equal value.
// Timing:
//   Every slot compares itself to the request value in parallel and shifts
//   one place in the same cycle, so a request updates the table as it is
//   accepted. The response is captured in the output register on acceptance;
//   a new request is accepted every cycle while the response is taken.
//   Rate is one request per cycle, set by the parallel compare/shift of
//   the slot chain.
// Reset:
//   rst_ni clears the count (table empty) and the output valid flag; slot
//   contents are left as they are and are never read before being written.
// Stall:
//   While m_axis_tready is low and a response waits, s_axis_tready drops and
//   the response is held stable.
module sorted_list_insert_remove_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] value (signed)
  input  logic [slriu_pkg::VALUE_W-1:0]        s_axis_tdata,
  // [0] func: 0 insert, 1 remove
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [1:0] status, [6:2] count, [7] zero
  output logic [slriu_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                                  accept;
  logic [CNT_W-1:0]                      count_q;
  logic [CNT_W-1:0]                      count_d;
  logic                                  out_valid_q;
  logic                                  out_valid_d;
  slriu_pkg::status_e                    status_d;
  slriu_pkg::status_e                    out_status_q;
  logic [slriu_pkg::COUNT_W-1:0]         out_count_q;
  logic [slriu_pkg::COUNT_W+CNT_W-1:0]   count_ext;
  logic                                  is_insert;
  logic                                  found;
  logic                                  full;
  logic                                  empty;
  slriu_pkg::cell_bcast_t                bcast;

  logic [CAPACITY-1:0]                   lt;
  logic [CAPACITY-1:0]                   eq;
  logic signed [slriu_pkg::VALUE_W-1:0]  cell_value [CAPACITY];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_insert     = (s_axis_tuser[0] == slriu_pkg::FUNC_INSERT);

  assign full  = (count_q >= CNT_W'(CAPACITY));
  assign empty = (count_q == '0);
  // Table is sorted, so any match starts right at the end of the "less" run.
  assign found = |eq;

  always_comb begin
    count_d  = count_q;
    status_d = slriu_pkg::ST_OK;
    bcast.insert = is_insert;
    bcast.value  = $signed(s_axis_tdata);
    bcast.wr_en  = 1'b0;
    if (is_insert) begin
      if (full) begin
        status_d = slriu_pkg::ST_FULL;
      end else begin
        bcast.wr_en = accept;
        count_d     = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = slriu_pkg::ST_EMPTY;
      end else if (!found) begin
        status_d = slriu_pkg::ST_NOT_FOUND;
      end else begin
        bcast.wr_en = accept;
        count_d     = count_q - CNT_W'(1);
      end
    end
  end

  assign count_ext = {slriu_pkg::COUNT_W'(0), count_d};

  // Slot chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                  left_lt;
    logic signed [slriu_pkg::VALUE_W-1:0]  left_value;
    logic signed [slriu_pkg::VALUE_W-1:0]  right_value;
    logic                                  occupied;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_value = bcast.value;
    end else begin : g_body
      assign left_lt    = lt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // Last slot becomes unused on a remove; its value is don't-care.
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    assign occupied = (count_q > CNT_W'(i));

    slriu_cell u_cell (
      .clk_i         (clk_i),
      .bcast_i       (bcast),
      .occupied_i    (occupied),
      .left_lt_i     (left_lt),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .lt_o          (lt[i]),
      .eq_o          (eq[i]),
      .value_o       (cell_value[i])
    );
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status_d;
      out_count_q  <= count_ext[slriu_pkg::COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_status_q};

endmodule

>>> hdl/slriu_checker.sv
// Port-level checker for the sorted list unit, bound to the top level.
// Depends on slriu_pkg and sorted_list_insert_remove_unit_defines.svh.
`include "sorted_list_insert_remove_unit_defines.svh"

module slriu_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [slriu_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  logic [slriu_pkg::COUNT_W-1:0] cap_count;

  assign cap_count = slriu_pkg::COUNT_W'(CAPACITY);

  // A waiting response stays put under back-pressure.
  `SLRIU_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "response changed while stalled")

  // Refused insert reports a full table.
  `SLRIU_ASSERT(a_full_count, m_axis_tvalid && (m_axis_tdata[1:0] == slriu_pkg::ST_FULL) |-> (m_axis_tdata[6:2] == cap_count), "full status with wrong count")

  // Remove on an empty table reports zero entries.
  `SLRIU_ASSERT(a_empty_count, m_axis_tvalid && (m_axis_tdata[1:0] == slriu_pkg::ST_EMPTY) |-> (m_axis_tdata[6:2] == '0), "empty status with nonzero count")

  // A miss only happens on a non-empty table (count field wraps above 31).
  `SLRIU_ASSERT(a_miss_count, m_axis_tvalid && (m_axis_tdata[1:0] == slriu_pkg::ST_NOT_FOUND) |-> (CAPACITY > 31) || (m_axis_tdata[6:2] != '0), "not-found status on empty table")

  // Count never exceeds the capacity.
  `SLRIU_ASSERT_ALWAYS(a_count_bound, m_axis_tvalid |-> (CAPACITY > 31) || (m_axis_tdata[6:2] <= cap_count), "count above capacity")

endmodule

bind sorted_list_insert_remove_unit slriu_checker #(.CAPACITY(CAPACITY)) u_slriu_checker (.*);
